// ===== rtl/cubic_spline_table_eval_core_macros.svh =====
// Assertion macros shared by the spline core.
`ifndef CUBIC_SPLINE_TABLE_EVAL_CORE_MACROS_SVH
`define CUBIC_SPLINE_TABLE_EVAL_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CSTE_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CSTE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CSTE_ASSERT_IMPLIES(label, ante, cons, msg)
`define CSTE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/cste_pkg.sv =====
`timescale 1ns / 1ps
package cste_pkg;

	localparam int NUM_INTERVALS = 64;
	localparam int NUM_CHANNELS  = 16;
	localparam int FRAC_BITS     = 16;
	localparam int MAX_RESULTS   = 16;
	localparam int CH_LIMIT      = (NUM_CHANNELS < MAX_RESULTS) ? NUM_CHANNELS : MAX_RESULTS;

	localparam int POS_W      = 22;
	localparam int COEF_W     = 32;
	localparam int VAL_W      = 32;
	localparam int ORDER_W    = 2;
	localparam int NUM_ORDERS = 4;
	localparam int IV_W       = 6;
	localparam int CHF_W      = 4;
	localparam int SEG_W      = $clog2(NUM_INTERVALS);
	localparam int CH_W       = $clog2(NUM_CHANNELS);
	localparam int TABLE_ROWS = NUM_INTERVALS * NUM_CHANNELS;

	localparam int CU_W       = 5;
	localparam int IU_W       = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CU_W-1:0] CU_RESET = CU_W'(16);
	localparam logic [IU_W-1:0] IU_RESET = IU_W'(64);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_EVAL  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANNELS_USED  = 2'd0,
		CFG_INTERVALS_USED = 2'd1
	} cfg_index_e;

	typedef struct packed {
		logic                     mode;
		logic [IV_W-1:0]          coef_interval;
		logic [CHF_W-1:0]         coef_channel;
		logic [ORDER_W-1:0]       coef_order;
		logic signed [COEF_W-1:0] coef_value;
		logic [POS_W-1:0]         position;
		logic                     last_point;
	} in_item_t;

	typedef struct packed {
		logic [CHF_W-1:0]        channel;
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] slope;
		logic                    out_of_range;
		logic                    last;
		logic                    batch_end;
	} result_t;

	typedef struct packed {
		logic [CH_W-1:0]  last_ch;
		logic [SEG_W-1:0] last_seg;
	} cfg_t;

	typedef struct packed {
		logic                     is_eval;
		logic [SEG_W-1:0]         seg;
		logic [CH_W-1:0]          ch;
		logic [ORDER_W-1:0]       order;
		logic [COEF_W-1:0]        coef;
		logic [FRAC_BITS-1:0]     frac;
		logic                     oor;
		logic                     batch;
		logic [CH_W-1:0]          last_ch;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

endpackage

// ===== rtl/cste_ram.sv =====
`timescale 1ns / 1ps
module cste_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/cste_front.sv =====
`timescale 1ns / 1ps
module cste_front import cste_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  in_item_t    item,
	input  cfg_t        cfg,
	input  logic        pop,
	output logic        busy,
	output queue_head_t head
);

	cmd_t              cmd;
	logic              push;
	logic              write_ok;
	logic [SEG_W-1:0]  seg_raw;
	cmd_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign busy     = (count_q == QCNT_W'(QDEPTH));
	assign seg_raw  = item.position[FRAC_BITS +: SEG_W];
	assign write_ok = (int'(item.coef_interval) < NUM_INTERVALS) &&
		(int'(item.coef_channel) < NUM_CHANNELS);

	always_comb begin
		cmd         = '0;
		cmd.is_eval = (item.mode == MODE_EVAL);
		if (item.mode == MODE_EVAL) begin
			cmd.last_ch = cfg.last_ch;
			cmd.batch   = item.last_point;
			if (seg_raw > cfg.last_seg) begin
				cmd.seg  = cfg.last_seg;
				cmd.frac = '1;
				cmd.oor  = 1'b1;
			end else begin
				cmd.seg  = seg_raw;
				cmd.frac = item.position[FRAC_BITS-1:0];
			end
		end else begin
			cmd.seg   = SEG_W'(item.coef_interval);
			cmd.ch    = CH_W'(item.coef_channel);
			cmd.order = item.coef_order;
			cmd.coef  = item.coef_value;
		end
	end

	// out-of-table writes are dropped here
	assign push   = start && !busy && ((item.mode == MODE_EVAL) || write_ok);
	assign do_pop = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd;
		end
	end

	assign head.valid = (count_q != '0);
	assign head.cmd   = q_mem_q[rd_ptr_q];

endmodule

// ===== rtl/cste_back.sv =====
`timescale 1ns / 1ps
module cste_back import cste_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_head_t head,
	output logic        pop,
	output logic        strobe,
	output result_t     result
);

	localparam int X_W    = FRAC_BITS + 1;
	localparam int D3_W   = COEF_W + 2;
	localparam int PV1_W  = COEF_W + X_W;
	localparam int PD1_W  = D3_W + X_W;
	localparam int V1_W   = COEF_W + 2;
	localparam int D1_W   = COEF_W + 4;
	localparam int PV2_W  = V1_W + X_W;
	localparam int PD2_W  = D1_W + X_W;
	localparam int V2_W   = COEF_W + 4;
	localparam int PV3_W  = V2_W + X_W;
	localparam int SUM_W  = COEF_W + 6;
	localparam int ROW_W  = $clog2(TABLE_ROWS);
	localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            fin;
		logic            oor;
		logic            batch;
	} side_t;

	function automatic logic signed [VAL_W-1:0] sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		r = v;
		if (v > SAT_HI) begin
			r = SAT_HI;
		end else if (v < SAT_LO) begin
			r = SAT_LO;
		end
		return r[VAL_W-1:0];
	endfunction

	// sequencer
	logic                 running_q;
	logic [CH_W-1:0]      ch_q;
	logic [CH_W-1:0]      last_ch_q;
	logic [SEG_W-1:0]     seg_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic                 oor_q;
	logic                 batch_q;
	logic                 fin;

	assign fin = (ch_q == last_ch_q);
	assign pop = head.valid && (!running_q || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			ch_q      <= '0;
		end else if (pop) begin
			running_q <= head.cmd.is_eval;
			ch_q      <= '0;
		end else if (running_q && fin) begin
			running_q <= 1'b0;
		end else if (running_q) begin
			ch_q <= ch_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			last_ch_q <= head.cmd.last_ch;
			seg_q     <= head.cmd.seg;
			frac_q    <= head.cmd.frac;
			oor_q     <= head.cmd.oor;
			batch_q   <= head.cmd.batch;
		end
	end

	// coefficient table, one bank per power
	logic [COEF_W-1:0] rdata [NUM_ORDERS];
	logic              wr_en;
	logic [ROW_W-1:0]  waddr;
	logic [ROW_W-1:0]  raddr;

	assign wr_en = pop && !head.cmd.is_eval;
	assign waddr = {head.cmd.seg, head.cmd.ch};
	assign raddr = {seg_q, ch_q};

	for (genvar o = 0; o < NUM_ORDERS; o++) begin : g_order
		cste_ram #(
			.WIDTH(COEF_W),
			.DEPTH(TABLE_ROWS)
		) u_ram (
			.clk  (clk),
			.we   (wr_en && (head.cmd.order == ORDER_W'(o))),
			.waddr(waddr),
			.wdata(head.cmd.coef),
			.raddr(raddr),
			.rdata(rdata[o])
		);
	end

	// arithmetic pipeline
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	side_t                    sd_s1, sd_s2, sd_s3, sd_s4;
	logic signed [X_W-1:0]    x_s1, x_s2, x_s3;
	logic signed [COEF_W-1:0] c0_s2, c1_s2, c2_s2, c0_s3, c1_s3, c0_s4;
	logic signed [PV1_W-1:0]  pv1_s2;
	logic signed [PD1_W-1:0]  pd1_s2;
	logic signed [PV2_W-1:0]  pv2_s3;
	logic signed [PD2_W-1:0]  pd2_s3;
	logic signed [PV3_W-1:0]  pv3_s4;
	logic signed [SUM_W-1:0]  dsum_s4;
	result_t                  result_s5;

	logic signed [COEF_W-1:0] c3;
	logic signed [D3_W-1:0]   d3;
	logic signed [V1_W-1:0]   v1;
	logic signed [D1_W-1:0]   d1;
	logic signed [V2_W-1:0]   v2;
	logic signed [SUM_W-1:0]  vsum;

	always_comb begin
		c3   = $signed(rdata[3]);
		d3   = D3_W'(c3) + (D3_W'(c3) <<< 1);
		v1   = V1_W'(c2_s2) + V1_W'(pv1_s2 >>> FRAC_BITS);
		d1   = (D1_W'(c2_s2) <<< 1) + D1_W'(pd1_s2 >>> FRAC_BITS);
		v2   = V2_W'(c1_s3) + V2_W'(pv2_s3 >>> FRAC_BITS);
		vsum = SUM_W'(c0_s4) + SUM_W'(pv3_s4 >>> FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= running_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		sd_s1.ch    <= ch_q;
		sd_s1.fin   <= fin;
		sd_s1.oor   <= oor_q;
		sd_s1.batch <= batch_q && fin;
		x_s1        <= $signed({1'b0, frac_q});

		sd_s2  <= sd_s1;
		x_s2   <= x_s1;
		c0_s2  <= $signed(rdata[0]);
		c1_s2  <= $signed(rdata[1]);
		c2_s2  <= $signed(rdata[2]);
		pv1_s2 <= c3 * x_s1;
		pd1_s2 <= d3 * x_s1;

		sd_s3  <= sd_s2;
		x_s3   <= x_s2;
		c0_s3  <= c0_s2;
		c1_s3  <= c1_s2;
		pv2_s3 <= v1 * x_s2;
		pd2_s3 <= d1 * x_s2;

		sd_s4   <= sd_s3;
		c0_s4   <= c0_s3;
		pv3_s4  <= v2 * x_s3;
		dsum_s4 <= SUM_W'(c1_s3) + SUM_W'(pd2_s3 >>> FRAC_BITS);

		result_s5.channel      <= CHF_W'(sd_s4.ch);
		result_s5.value        <= sat(vsum);
		result_s5.slope        <= sat(dsum_s4);
		result_s5.out_of_range <= sd_s4.oor;
		result_s5.last         <= sd_s4.fin;
		result_s5.batch_end    <= sd_s4.batch;
	end

	assign strobe = v_s5;
	assign result = result_s5;

endmodule

// ===== rtl/cubic_spline_table_eval_core.sv =====
`timescale 1ns / 1ps
// Write item: queued, then applied to the table when the back end pops it; no result.
// Evaluate item: through the queue, sequencer, table read and stages s1-s5; one result per cycle.
// Throughput: one coefficient row read a cycle while an evaluate runs, one row per channel in use.
// busy rises when the two-entry command queue is full; results cannot be stalled.
// Reset clears control state and sets channels_used to 16, intervals_used to 64.
// The coefficient table is not cleared by reset.
`include "cubic_spline_table_eval_core_macros.svh"
module cubic_spline_table_eval_core import cste_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_item_t              item,
	output logic                  strobe,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CU_W-1:0] channels_used_q;
	logic [IU_W-1:0] intervals_used_q;
	cfg_t            cfg;
	queue_head_t     head;
	logic            pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_used_q  <= CU_RESET;
			intervals_used_q <= IU_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CHANNELS_USED: begin
					channels_used_q <= cfg_data[CU_W-1:0];
				end
				CFG_INTERVALS_USED: begin
					intervals_used_q <= cfg_data[IU_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (channels_used_q == '0) begin
			cfg.last_ch = '0;
		end else if (int'(channels_used_q) > CH_LIMIT) begin
			cfg.last_ch = CH_W'(CH_LIMIT - 1);
		end else begin
			cfg.last_ch = CH_W'(channels_used_q - 1'b1);
		end
		if (intervals_used_q == '0) begin
			cfg.last_seg = '0;
		end else if (int'(intervals_used_q) > NUM_INTERVALS) begin
			cfg.last_seg = SEG_W'(NUM_INTERVALS - 1);
		end else begin
			cfg.last_seg = SEG_W'(intervals_used_q - 1'b1);
		end
	end

	cste_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.cfg   (cfg),
		.pop   (pop),
		.busy  (busy),
		.head  (head)
	);

	cste_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.pop   (pop),
		.strobe(strobe),
		.result(result)
	);

	`CSTE_ASSERT_IMPLIES(a_last_channel, strobe && result.last,
		result.channel == CHF_W'(cfg.last_ch), "last result not on last channel")
	`CSTE_ASSERT_IMPLIES(a_batch_on_last, strobe && result.batch_end,
		result.last, "batch_end without last")
	`CSTE_ASSERT_NEXT(a_channel_run, strobe && !result.last,
		strobe && (result.channel == CHF_W'($past(result.channel) + 1'b1)),
		"channel run broken")

endmodule

// ===== tb/sv/cubic_spline_table_eval_core_tb.sv =====
`timescale 1ns / 1ps
module cubic_spline_table_eval_core_tb;
	import cste_pkg::*;

	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_CYCLES  = 40;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 18;
	localparam int COEF_WORDS    = TABLE_ROWS * NUM_ORDERS;

	localparam logic [CFG_DATA_W-1:0] PHASE_CHANNELS [PHASES] =
		'{8'd16, 8'd0, 8'd5, 8'hFF, 8'd1, 8'hE3};
	localparam logic [CFG_DATA_W-1:0] PHASE_INTERVALS [PHASES] =
		'{8'd64, 8'd0, 8'd10, 8'hFF, 8'd64, 8'hA1};

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_WRITE,
		ROW_EVAL
	} row_kind_e;

	typedef struct {
		row_kind_e             kind;
		cfg_index_e            reg_idx;
		logic [CFG_DATA_W-1:0] reg_data;
		in_item_t              it;
		bit                    typed;
		result_t               want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	in_item_t              item = '0;
	logic                  strobe;
	result_t               result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic signed [COEF_W-1:0] coef_mem [COEF_WORDS];
	bit                       coef_loaded [COEF_WORDS];
	logic [CU_W-1:0]          cur_channels = CU_RESET;
	logic [IU_W-1:0]          cur_intervals = IU_RESET;

	result_t    expected_results [$];
	result_t    want_beat;
	stim_row_t  directed_rows [$];
	int         errors = 0;
	int         stall_cycles = 0;
	bit         dense = 1'b0;

	cubic_spline_table_eval_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.strobe    (strobe),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int coef_addr(int seg, int ch, int ord);
		return (seg * NUM_CHANNELS + ch) * NUM_ORDERS + ord;
	endfunction

	function automatic int eff_channels();
		int n;
		n = int'(cur_channels);
		if (n < 1) n = 1;
		if (n > CH_LIMIT) n = CH_LIMIT;
		return n;
	endfunction

	function automatic int eff_intervals();
		int n;
		n = int'(cur_intervals);
		if (n < 1) n = 1;
		if (n > NUM_INTERVALS) n = NUM_INTERVALS;
		return n;
	endfunction

	function automatic bit seg_ready(int seg);
		bit ok;
		ok = 1'b1;
		for (int ch = 0; ch < eff_channels(); ch++)
			for (int ord = 0; ord < NUM_ORDERS; ord++)
				if (!coef_loaded[coef_addr(seg, ch, ord)]) ok = 1'b0;
		return ok;
	endfunction

	// past the last interval in use: clamp to it with the fraction at its maximum
	function automatic void locate(input logic [POS_W-1:0] pos, output int seg,
			output longint x, output bit oor);
		int ip;
		int nint;
		ip = int'(pos[POS_W-1:FRAC_BITS]);
		nint = eff_intervals();
		if (ip >= nint) begin
			seg = nint - 1;
			x = (longint'(1) << FRAC_BITS) - 1;
			oor = 1'b1;
		end else begin
			seg = ip;
			x = longint'(pos[FRAC_BITS-1:0]);
			oor = 1'b0;
		end
	endfunction

	function automatic logic signed [VAL_W-1:0] sat32(longint v);
		if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
		if (v < -longint'(64'h8000_0000)) return 32'sh8000_0000;
		return v[VAL_W-1:0];
	endfunction

	// Horner for the value, the same nesting for the derivative; products floor-shifted
	function automatic void predict_eval(in_item_t it);
		int      seg;
		int      nch;
		longint  x;
		bit      oor;
		longint  c0, c1, c2, c3, v, d;
		result_t r;
		locate(it.position, seg, x, oor);
		nch = eff_channels();
		for (int ch = 0; ch < nch; ch++) begin
			c0 = coef_mem[coef_addr(seg, ch, 0)];
			c1 = coef_mem[coef_addr(seg, ch, 1)];
			c2 = coef_mem[coef_addr(seg, ch, 2)];
			c3 = coef_mem[coef_addr(seg, ch, 3)];
			v = c3;
			v = c2 + ((v * x) >>> FRAC_BITS);
			v = c1 + ((v * x) >>> FRAC_BITS);
			v = c0 + ((v * x) >>> FRAC_BITS);
			d = 3 * c3;
			d = 2 * c2 + ((d * x) >>> FRAC_BITS);
			d = c1 + ((d * x) >>> FRAC_BITS);
			r.channel = CHF_W'(ch);
			r.value = sat32(v);
			r.slope = sat32(d);
			r.out_of_range = oor;
			r.last = (ch == nch - 1);
			r.batch_end = (ch == nch - 1) && it.last_point;
			expected_results.push_back(r);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (dense) return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 80) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [COEF_W-1:0] rand_coef();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 32'sh0;
					default: return -32'sh1;
				endcase
			end
			1, 2: return $urandom();
			3, 4, 5: return int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
			default: return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
		endcase
	endfunction

	function automatic in_item_t noise_item();
		logic [95:0] bits;
		bits = {$urandom(), $urandom(), $urandom()};
		return bits[$bits(in_item_t)-1:0];
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int       nint;
		int       ip;
		int       frac;
		it = noise_item();
		nint = eff_intervals();
		if ($urandom_range(0, 99) < 60) begin
			it.mode = MODE_EVAL;
			if ($urandom_range(0, 99) < 15 && nint < NUM_INTERVALS)
				ip = $urandom_range(nint, NUM_INTERVALS - 1);
			else begin
				ip = $urandom_range(0, nint - 1);
				// stay on intervals already loaded, else the first or the last one
				if (!seg_ready(ip))
					ip = ($urandom_range(0, 1) == 0) ? 0 : nint - 1;
			end
			case ($urandom_range(0, 9))
				0: frac = 0;
				1: frac = (1 << FRAC_BITS) - 1;
				default: frac = $urandom_range(0, (1 << FRAC_BITS) - 1);
			endcase
			it.position = (POS_W'(ip) << FRAC_BITS) | POS_W'(frac);
		end else begin
			it.mode = MODE_WRITE;
			it.coef_value = rand_coef();
		end
		return it;
	endfunction

	function automatic stim_row_t cfg_row(cfg_index_e idx, logic [CFG_DATA_W-1:0] data);
		stim_row_t r = '{ROW_CFG, CFG_CHANNELS_USED, '0, '0, 1'b0, '0};
		r.reg_idx = idx;
		r.reg_data = data;
		return r;
	endfunction

	function automatic stim_row_t coef_row(int iv, int ch, int ord, logic [COEF_W-1:0] val);
		stim_row_t r = '{ROW_WRITE, CFG_CHANNELS_USED, '0, '0, 1'b0, '0};
		r.it.mode = MODE_WRITE;
		r.it.coef_interval = IV_W'(iv);
		r.it.coef_channel = CHF_W'(ch);
		r.it.coef_order = ORDER_W'(ord);
		r.it.coef_value = val;
		return r;
	endfunction

	function automatic stim_row_t eval_row(logic [POS_W-1:0] pos, bit lp);
		stim_row_t r = '{ROW_EVAL, CFG_CHANNELS_USED, '0, '0, 1'b0, '0};
		r.it.mode = MODE_EVAL;
		r.it.position = pos;
		r.it.last_point = lp;
		return r;
	endfunction

	// single channel in use, so the one result is also the last of the position
	function automatic stim_row_t eval_typed(logic [POS_W-1:0] pos, bit lp,
			logic [VAL_W-1:0] val, logic [VAL_W-1:0] slp, bit oor);
		stim_row_t r;
		r = eval_row(pos, lp);
		r.typed = 1'b1;
		r.want.channel = '0;
		r.want.value = val;
		r.want.slope = slp;
		r.want.out_of_range = oor;
		r.want.last = 1'b1;
		r.want.batch_end = lp;
		return r;
	endfunction

	task automatic send_item(in_item_t it, bit typed, result_t want);
		int gap;
		int a;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		if (it.mode == MODE_WRITE) begin
			a = coef_addr(it.coef_interval, it.coef_channel, it.coef_order);
			coef_mem[a] = it.coef_value;
			coef_loaded[a] = 1'b1;
		end else if (typed) begin
			expected_results.push_back(want);
		end else begin
			predict_eval(it);
		end
	endtask

	// an evaluate must never touch a coefficient that was never written
	task automatic load_missing_coefs(in_item_t ev);
		int       seg;
		longint   x;
		bit       oor;
		in_item_t w;
		locate(ev.position, seg, x, oor);
		for (int ch = 0; ch < eff_channels(); ch++) begin
			for (int ord = 0; ord < NUM_ORDERS; ord++) begin
				if (!coef_loaded[coef_addr(seg, ch, ord)]) begin
					w = noise_item();
					w.mode = MODE_WRITE;
					w.coef_interval = IV_W'(seg);
					w.coef_channel = CHF_W'(ch);
					w.coef_order = ORDER_W'(ord);
					w.coef_value = rand_coef();
					send_item(w, 1'b0, '0);
				end
			end
		end
	endtask

	task automatic write_reg(cfg_index_e idx, logic [CFG_DATA_W-1:0] data);
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES + pick_gap()) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CHANNELS_USED:  cur_channels = data[CU_W-1:0];
			CFG_INTERVALS_USED: cur_intervals = data[IU_W-1:0];
			default: ;
		endcase
	endtask

	task automatic run_item(in_item_t it, bit typed, result_t want);
		if (it.mode == MODE_EVAL) load_missing_coefs(it);
		send_item(it, typed, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected: channel %0d", result.channel);
				errors++;
			end else begin
				want_beat = expected_results.pop_front();
				if (result.channel !== want_beat.channel) begin
					$error("channel: expected %0d, got %0d", want_beat.channel, result.channel);
					errors++;
				end
				if (result.value !== want_beat.value) begin
					$error("value: expected %0d, got %0d", want_beat.value, result.value);
					errors++;
				end
				if (result.slope !== want_beat.slope) begin
					$error("slope: expected %0d, got %0d", want_beat.slope, result.slope);
					errors++;
				end
				if (result.out_of_range !== want_beat.out_of_range) begin
					$error("out_of_range: expected %0b, got %0b",
						want_beat.out_of_range, result.out_of_range);
					errors++;
				end
				if (result.last !== want_beat.last) begin
					$error("last: expected %0b, got %0b", want_beat.last, result.last);
					errors++;
				end
				if (result.batch_end !== want_beat.batch_end) begin
					$error("batch_end: expected %0b, got %0b",
						want_beat.batch_end, result.batch_end);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("cubic_spline_table_eval_core test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		// reset config: last interval, then the first one, all channels
		directed_rows.push_back(eval_row(22'h3F_8000, 1'b1));
		directed_rows.push_back(eval_row(22'h00_0000, 1'b0));
		directed_rows.push_back(cfg_row(CFG_CHANNELS_USED, 8'd1));
		directed_rows.push_back(cfg_row(CFG_INTERVALS_USED, 8'd2));
		directed_rows.push_back(coef_row(0, 0, 0, 32'h7FFF_FFFF));
		directed_rows.push_back(coef_row(0, 0, 1, 32'h8000_0000));
		directed_rows.push_back(coef_row(0, 0, 2, 32'h0));
		directed_rows.push_back(coef_row(0, 0, 3, 32'h0));
		directed_rows.push_back(eval_typed(22'h00_0000, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
		directed_rows.push_back(eval_row(22'h00_FFFF, 1'b0));
		for (int ord = 0; ord < NUM_ORDERS; ord++)
			directed_rows.push_back(coef_row(1, 0, ord, 32'h7FFF_FFFF));
		// clamped positions, saturating high
		directed_rows.push_back(eval_typed(22'h3F_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
		directed_rows.push_back(eval_typed(22'h02_0000, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
		for (int ord = 0; ord < NUM_ORDERS; ord++)
			directed_rows.push_back(coef_row(1, 0, ord, 32'h8000_0000));
		directed_rows.push_back(eval_typed(22'h3F_FFFF, 1'b1, 32'h8000_0000, 32'h8000_0000, 1'b1));
		// zero in both registers acts as one
		directed_rows.push_back(cfg_row(CFG_CHANNELS_USED, 8'd0));
		directed_rows.push_back(cfg_row(CFG_INTERVALS_USED, 8'd0));
		directed_rows.push_back(eval_typed(22'h00_0000, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
		directed_rows.push_back(eval_row(22'h2A_5A5A, 1'b0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
			else
				run_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_reg(CFG_CHANNELS_USED, PHASE_CHANNELS[p]);
			write_reg(CFG_INTERVALS_USED, PHASE_INTERVALS[p]);
			dense = (p % 3 == 1);
			for (int n = 0; n < PHASE_ITEMS; n++)
				run_item(random_item(), 1'b0, '0);
		end

		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("cubic_spline_table_eval_core test passed");
		else
			$display("cubic_spline_table_eval_core test failed");
		$finish;
	end

endmodule
